@@ src/stq_pkg.sv @@
// Shared types and constants for the sorted timer queue.
`default_nettype none
package stq_pkg;

  localparam logic       CMD_ADD     = 1'b0;
  localparam logic       CMD_SERVICE = 1'b1;

  localparam logic [1:0] KIND_ACK    = 2'd0;
  localparam logic [1:0] KIND_FIRED  = 2'd1;
  localparam logic [1:0] KIND_DONE   = 2'd2;

  localparam logic [1:0] STS_OK      = 2'd0;
  localparam logic [1:0] STS_NEG     = 2'd1;
  localparam logic [1:0] STS_FULL    = 2'd2;

  localparam logic [63:0] NO_DEADLINE = 64'hFFFF_FFFF_FFFF_FFFF;
  localparam logic [31:0] TPS_RESET   = 32'd10000000;

  typedef struct packed {
    logic [63:0] deadline;
    logic [7:0]  handler;
    logic [31:0] argument;
  } entry_t;

  // chain-wide operation for the current cycle
  typedef struct packed {
    logic ins;
    logic pop;
  } cell_ctl_t;

endpackage
`default_nettype wire

@@ src/stq_cell.sv @@
// One slot of the sorted timer chain: holds, shifts right on insert, shifts left on pop.
`default_nettype none
module stq_cell
  import stq_pkg::*;
(
  input  wire logic      clk,
  input  wire cell_ctl_t ctl,
  input  wire logic      occupied,
  input  wire entry_t    new_ent,
  input  wire logic      left_keep,
  input  wire entry_t    left_ent,
  input  wire entry_t    right_ent,
  output logic           keep,
  output entry_t         ent
);

  entry_t ent_r;
  entry_t ent_nxt;

  // entry stays put when it sorts at or before the new deadline
  assign keep = occupied && (ent_r.deadline <= new_ent.deadline);
  assign ent  = ent_r;

  always_comb begin
    ent_nxt = ent_r;
    if (ctl.ins) begin
      if (!keep) begin
        ent_nxt = left_keep ? new_ent : left_ent;
      end
    end else if (ctl.pop) begin
      ent_nxt = right_ent;
    end
  end

  always_ff @(posedge clk) begin
    ent_r <= ent_nxt;
  end

endmodule
`default_nettype wire

@@ src/sorted_timer_queue_top.sv @@
// Top level of the sorted timer queue: control sequencer around a chain of timer cells.
//
// Keeps up to DEPTH pending timers sorted by 64-bit absolute deadline in a
// chain of cells; cell 0 always holds the earliest one. Issue a transaction
// with start while busy is low. An add transaction passes through these
// steps to its single acknowledge: capture, the 32x32 delay*ticks multiply,
// the 64-bit deadline add and the parallel compare-and-shift insert across
// the chain. A rejected add (negative delay, queue full) is acknowledged
// the cycle after it is taken. A service transaction pops one expired timer
// per cycle from the head of the chain: capture, one pop per expired entry,
// then the head check that finds nothing due, ending in one finished
// result. Results are presented for exactly one cycle with out_valid; the
// receiver cannot stall them and must take every one. busy drops in the
// cycle the final result (out_last) is shown, so the next transaction may
// start then.
`default_nettype none
module sorted_timer_queue_top
  import stq_pkg::*;
#(
  parameter int DEPTH = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  // command channel
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_cmd,
  input  wire logic [63:0]        in_now,
  input  wire logic signed [31:0] in_delay_sec,
  input  wire logic [7:0]         in_callback_id,
  input  wire logic [31:0]        in_argument,
  // result channel
  output logic                    out_valid,
  output logic [1:0]              out_kind,
  output logic [1:0]              out_status,
  output logic [7:0]              out_fired_callback,
  output logic [31:0]             out_fired_argument,
  output logic [63:0]             out_next_deadline,
  output logic                    out_last,
  // configuration
  input  wire logic               cfg_we,
  input  wire logic [31:0]        cfg_wdata
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  // sequencer states
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_MUL  = 3'd1;
  localparam logic [2:0] S_ADD  = 3'd2;
  localparam logic [2:0] S_INS  = 3'd3;
  localparam logic [2:0] S_SVC  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [31:0]      tps_r;

  // captured transaction
  logic [63:0] now_r;
  logic [31:0] dly_r;
  logic [7:0]  cb_r;
  logic [31:0] arg_r;
  logic [63:0] mul_r;
  logic [63:0] ddl_r;

  // result registers
  logic        ov_r, ov_nxt;
  logic [1:0]  kind_r, kind_nxt;
  logic [1:0]  sts_r, sts_nxt;
  logic [7:0]  fcb_r, fcb_nxt;
  logic [31:0] farg_r, farg_nxt;
  logic [63:0] nd_r, nd_nxt;
  logic        last_r, last_nxt;

  cell_ctl_t ctl;
  entry_t    new_ent;
  entry_t    cell_q [DEPTH];
  logic      keep_q [DEPTH];

  logic        accept;
  logic        full;
  logic [63:0] front_dl;
  logic        head_due;

  assign accept   = start && (state_r == S_IDLE);
  assign full     = (cnt_r == CNT_W'(DEPTH));
  // head deadline as the queue stands now (all ones when empty)
  assign front_dl = (cnt_r == '0) ? NO_DEADLINE : cell_q[0].deadline;
  assign head_due = (cnt_r != '0) && (cell_q[0].deadline <= now_r);

  assign new_ent.deadline = ddl_r;
  assign new_ent.handler  = cb_r;
  assign new_ent.argument = arg_r;

  // ---------------------------------------------------------------------
  // Cell chain. Each cell sees its neighbors; cell 0 has no left neighbor
  // and the last cell refills from itself on a pop.
  // ---------------------------------------------------------------------
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic   lk;
    entry_t le;
    entry_t re;
    if (i == 0) begin : g_first
      assign lk = 1'b1;
      assign le = new_ent;
    end else begin : g_mid
      assign lk = keep_q[i-1];
      assign le = cell_q[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign re = cell_q[i];
    end else begin : g_inner
      assign re = cell_q[i+1];
    end
    stq_cell u_cell (
      .clk       (clk),
      .ctl       (ctl),
      .occupied  (CNT_W'(i) < cnt_r),
      .new_ent   (new_ent),
      .left_keep (lk),
      .left_ent  (le),
      .right_ent (re),
      .keep      (keep_q[i]),
      .ent       (cell_q[i])
    );
  end

  // ---------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    ctl       = '0;
    ov_nxt    = 1'b0;
    kind_nxt  = KIND_ACK;
    sts_nxt   = STS_OK;
    fcb_nxt   = '0;
    farg_nxt  = '0;
    nd_nxt    = '0;
    last_nxt  = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept) begin
          if (in_cmd == CMD_SERVICE) begin
            state_nxt = S_SVC;
          end else if (in_delay_sec[31]) begin
            ov_nxt   = 1'b1;
            sts_nxt  = STS_NEG;
            nd_nxt   = front_dl;
            last_nxt = 1'b1;
          end else if (full) begin
            ov_nxt   = 1'b1;
            sts_nxt  = STS_FULL;
            nd_nxt   = front_dl;
            last_nxt = 1'b1;
          end else begin
            state_nxt = S_MUL;
          end
        end
      end
      S_MUL: begin
        state_nxt = S_ADD;
      end
      S_ADD: begin
        state_nxt = S_INS;
      end
      S_INS: begin
        ctl.ins   = 1'b1;
        cnt_nxt   = cnt_r + 1'b1;
        ov_nxt    = 1'b1;
        // head after insert: old head if it stays, else the new timer
        nd_nxt    = keep_q[0] ? cell_q[0].deadline : ddl_r;
        last_nxt  = 1'b1;
        state_nxt = S_IDLE;
      end
      S_SVC: begin
        if (head_due) begin
          ctl.pop = 1'b1;
          cnt_nxt = cnt_r - 1'b1;
          if (cell_q[0].handler != '0) begin
            ov_nxt   = 1'b1;
            kind_nxt = KIND_FIRED;
            fcb_nxt  = cell_q[0].handler;
            farg_nxt = cell_q[0].argument;
          end
        end else begin
          ov_nxt    = 1'b1;
          kind_nxt  = KIND_DONE;
          nd_nxt    = front_dl;
          last_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
      tps_r   <= TPS_RESET;
      ov_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      ov_r    <= ov_nxt;
      if (cfg_we) begin
        tps_r <= cfg_wdata;
      end
    end
  end

  // datapath and result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      now_r <= in_now;
      dly_r <= $unsigned(in_delay_sec);
      cb_r  <= in_callback_id;
      arg_r <= in_argument;
    end
    mul_r  <= 64'(dly_r) * 64'(tps_r);  // 32x32 -> 64
    ddl_r  <= now_r + mul_r;  // wraps mod 2^64
    kind_r <= kind_nxt;
    sts_r  <= sts_nxt;
    fcb_r  <= fcb_nxt;
    farg_r <= farg_nxt;
    nd_r   <= nd_nxt;
    last_r <= last_nxt;
  end

  assign busy               = (state_r != S_IDLE);
  assign out_valid          = ov_r;
  assign out_kind           = kind_r;
  assign out_status         = sts_r;
  assign out_fired_callback = fcb_r;
  assign out_fired_argument = farg_r;
  assign out_next_deadline  = nd_r;
  assign out_last           = last_r;

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CNT_W'(DEPTH))
    else $error("pending count above depth");

  a_cnt_step: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> (cnt_r == $past(cnt_r)) ||
                     (cnt_r == CNT_W'($past(cnt_r) + 1'b1)) ||
                     (cnt_r == CNT_W'($past(cnt_r) - 1'b1)))
    else $error("pending count moved by more than one");

  a_last_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && last_r) |-> (state_r == S_IDLE))
    else $error("final result shown while still busy");

  a_head_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r >= CNT_W'(2)) |-> (cell_q[0].deadline <= cell_q[1].deadline))
    else $error("chain head out of order");

endmodule
`default_nettype wire
